[rtl/core/encoder_ring_led_mask_assert.svh]
// Assertion macros for the encoder ring LED mask block.
`ifndef ENCODER_RING_LED_MASK_ASSERT_SVH
`define ENCODER_RING_LED_MASK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent in one cycle implies consequent in the next; clocked on clk_i, off in reset.
`define ERLM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Condition must never hold outside reset.
`define ERLM_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define ERLM_ASSERT_NEXT(label, ante, cons, msg)
`define ERLM_ASSERT_NEVER(label, cond, msg)

`endif

`endif

[rtl/core/erlm_pkg.sv]
// Package: display modes, scaling constants and mask helpers for the encoder ring.
package erlm_pkg;

  typedef enum logic [2:0] {
    ActFillUp   = 3'd0,
    ActPosition = 3'd1,
    ActBalance  = 3'd2,
    ActWidth    = 3'd3,
    ActFillDown = 3'd4,
    ActCount    = 3'd5,
    ActBit      = 3'd6,
    ActDbfs     = 3'd7
  } action_e;

  typedef logic [15:0] mask_t;

  // Reciprocal multipliers: floor(x/100) for x < 4681, floor(y/99) for y < 32768.
  localparam logic [10:0] Div100Mul   = 11'd1311;
  localparam logic [10:0] Div99Mul    = 11'd1324;
  localparam int unsigned RecipShift  = 17;

  localparam logic [3:0] LedLast   = 4'd12;
  localparam logic [3:0] LedCentre = 4'd6;
  localparam logic [3:0] FillMax   = 4'd13;

  // dBFS thresholds, tenths of a dB.
  localparam logic signed [11:0] DbFloor = -12'sd600;
  localparam logic signed [11:0] DbT12   = 12'sd100;
  localparam logic signed [11:0] DbT11   = 12'sd60;
  localparam logic signed [11:0] DbT10   = 12'sd30;
  localparam logic signed [11:0] DbT9    = 12'sd0;
  localparam logic signed [11:0] DbT8    = -12'sd30;
  localparam logic signed [11:0] DbT7    = -12'sd60;
  localparam logic signed [11:0] DbT6    = -12'sd90;
  localparam logic signed [11:0] DbT5    = -12'sd120;
  localparam logic signed [11:0] DbT4    = -12'sd180;
  localparam logic signed [11:0] DbT3    = -12'sd240;
  localparam logic signed [11:0] DbT2    = -12'sd300;
  localparam logic signed [11:0] DbT1    = -12'sd400;

  function automatic logic [5:0] div100(input logic [11:0] x);
    logic [22:0] p;
    p = 23'(x) * 23'(Div100Mul);
    return p[22:RecipShift];
  endfunction

  // floor(x/198) as floor(floor(x/2)/99)
  function automatic logic [4:0] div198(input logic [11:0] x);
    logic [21:0] p;
    p = 22'(x[11:1]) * 22'(Div99Mul);
    return p[21:RecipShift];
  endfunction

  function automatic mask_t low_bits(input logic [4:0] n);
    mask_t m;
    for (int i = 0; i < 16; i++) begin
      m[i] = (5'(i) < n);
    end
    return m;
  endfunction

  function automatic mask_t span(input logic [4:0] lo, input logic [4:0] hi);
    mask_t m;
    if (hi < lo) begin
      m = '0;
    end else begin
      m = low_bits(hi + 5'd1) & ~low_bits(lo);
    end
    return m;
  endfunction

endpackage

[rtl/core/encoder_ring_led_mask.sv]
// Top level: encoder ring LED mask generator with a registered result stage.
//
// Turns one ring request (display mode, percentage or count, dBFS level in
// tenths of a dB, single-LED flag, backlight) into the two data bytes for a
// 13-LED encoder ring. LED 0 is the counter-clockwise end, LED 6 the centre,
// LED 12 the clockwise end. ring_low_byte_o carries mask bits 0..7;
// ring_high_byte_o carries mask bits 8..14 in bits 0..6 and the backlight in
// bit 7. Every request gives exactly one result. The result is registered: a
// request accepted in a cycle is presented on the output in the next. One
// request per cycle is sustained; the single output register sets this, and
// in_ready_o only drops while that register holds a result the consumer has
// not yet taken. All scaling is exact integer arithmetic (constant-reciprocal
// multiplies), so there is no iteration and no state beyond the output stage.
module encoder_ring_led_mask (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [7:0]         percent_i,
  input  logic signed [11:0] level_tenth_db_i,
  input  logic               only_position_i,
  input  logic               backlight_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         ring_low_byte_o,
  output logic [7:0]         ring_high_byte_o
);

`include "encoder_ring_led_mask_assert.svh"

  erlm_pkg::mask_t mask;
  logic            in_xfer;
  logic            valid_d, valid_q;
  logic [7:0]      low_d, low_q;
  logic [7:0]      high_d, high_q;

  // Mode decode and scaling: purely combinational.
  erlm_mapper u_mapper (
    .action_i         (action_i),
    .percent_i        (percent_i),
    .level_tenth_db_i (level_tenth_db_i),
    .only_position_i  (only_position_i),
    .mask_o           (mask)
  );

  // Take a new request whenever the output stage is empty or being emptied.
  assign in_ready_o = !valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (in_xfer) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  // Mask bit 15 is never sent.
  assign low_d  = mask[7:0];
  assign high_d = {backlight_i, mask[14:8]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload: loaded on transfer only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      low_q  <= low_d;
      high_q <= high_d;
    end
  end

  assign out_valid_o      = valid_q;
  assign ring_low_byte_o  = low_q;
  assign ring_high_byte_o = high_q;

  // Checks
  `ERLM_ASSERT_NEXT(a_xfer_gives_result, in_valid_i && in_ready_o, out_valid_o, "accepted request gave no result")
  `ERLM_ASSERT_NEXT(a_backlight_passes, in_valid_i && in_ready_o, ring_high_byte_o[7] == $past(backlight_i), "backlight bit lost")
  `ERLM_ASSERT_NEXT(a_drain_clears, out_valid_o && out_ready_i && !(in_valid_i && in_ready_o), !out_valid_o, "result repeated after transfer")
  `ERLM_ASSERT_NEVER(a_stall_blocks_input, out_valid_o && !out_ready_i && in_ready_o, "request taken over a waiting result")

endmodule

[rtl/core/erlm_mapper.sv]
// Combinational mapping from one ring request to the 16-bit LED mask.
module erlm_mapper (
  input  logic [2:0]         action_i,
  input  logic [7:0]         percent_i,
  input  logic signed [11:0] level_tenth_db_i,
  input  logic               only_position_i,
  output erlm_pkg::mask_t    mask_o
);

  logic [4:0]  fill_raw;
  logic [3:0]  fill_n;
  logic [5:0]  pos_raw;
  logic [3:0]  pos_n;
  logic [5:0]  bal_lo_raw;
  logic [4:0]  bal_lo_n;
  logic [5:0]  bal_hi_raw;
  logic [4:0]  bal_hi_n;
  logic [4:0]  wid_raw;
  logic [3:0]  wid_n;
  logic [3:0]  cnt_n;
  logic [3:0]  db_idx;
  logic [7:0]  pct_m50;
  logic [7:0]  pct_m1;

  assign pct_m50 = percent_i - 8'd50;
  assign pct_m1  = percent_i - 8'd1;

  assign fill_raw = percent_i[7:3];
  assign fill_n   = (fill_raw > 5'(erlm_pkg::FillMax)) ? erlm_pkg::FillMax : fill_raw[3:0];

  assign pos_raw = erlm_pkg::div100(12'(percent_i) * 12'd12 + 12'd50);
  assign pos_n   = (pos_raw > 6'(erlm_pkg::LedLast)) ? erlm_pkg::LedLast : pos_raw[3:0];

  // Balance: left half rounds percent*6.5/50, right half 1 + (percent-50)*6.5/50
  assign bal_lo_raw = erlm_pkg::div100(12'(percent_i) * 12'd13 + 12'd50);
  assign bal_lo_n   = (bal_lo_raw == 6'd0) ? 5'd1 :
                      (bal_lo_raw > 6'd7) ? 5'd7 : bal_lo_raw[4:0];
  assign bal_hi_raw = erlm_pkg::div100(12'd150 + 12'(pct_m50) * 12'd13);
  assign bal_hi_n   = (bal_hi_raw > 6'd7) ? 5'd7 : bal_hi_raw[4:0];

  assign wid_raw = erlm_pkg::div198(12'(pct_m1) * 12'd12 + 12'd99);
  assign wid_n   = (wid_raw > 5'd6) ? 4'd6 : wid_raw[3:0];

  assign cnt_n = (percent_i > 8'(erlm_pkg::FillMax)) ? erlm_pkg::FillMax : percent_i[3:0];

  always_comb begin
    if      (level_tenth_db_i >= erlm_pkg::DbT12) db_idx = 4'd12;
    else if (level_tenth_db_i >= erlm_pkg::DbT11) db_idx = 4'd11;
    else if (level_tenth_db_i >= erlm_pkg::DbT10) db_idx = 4'd10;
    else if (level_tenth_db_i >= erlm_pkg::DbT9)  db_idx = 4'd9;
    else if (level_tenth_db_i >= erlm_pkg::DbT8)  db_idx = 4'd8;
    else if (level_tenth_db_i >= erlm_pkg::DbT7)  db_idx = 4'd7;
    else if (level_tenth_db_i >= erlm_pkg::DbT6)  db_idx = 4'd6;
    else if (level_tenth_db_i >= erlm_pkg::DbT5)  db_idx = 4'd5;
    else if (level_tenth_db_i >= erlm_pkg::DbT4)  db_idx = 4'd4;
    else if (level_tenth_db_i >= erlm_pkg::DbT3)  db_idx = 4'd3;
    else if (level_tenth_db_i >= erlm_pkg::DbT2)  db_idx = 4'd2;
    else if (level_tenth_db_i >= erlm_pkg::DbT1)  db_idx = 4'd1;
    else                                          db_idx = 4'd0;
  end

  always_comb begin
    mask_o = '0;
    case (erlm_pkg::action_e'(action_i))
      erlm_pkg::ActFillUp: begin
        mask_o = erlm_pkg::low_bits(5'(fill_n));
      end
      erlm_pkg::ActFillDown: begin
        if (fill_n != 4'd0) begin
          mask_o = erlm_pkg::span(5'(erlm_pkg::FillMax - fill_n), 5'(erlm_pkg::LedLast));
        end
      end
      erlm_pkg::ActPosition: begin
        mask_o[pos_n] = 1'b1;
      end
      erlm_pkg::ActBalance: begin
        if (percent_i < 8'd50) begin
          mask_o = erlm_pkg::span(bal_lo_n, 5'(erlm_pkg::LedCentre));
        end else begin
          mask_o = erlm_pkg::span(5'(erlm_pkg::LedCentre), bal_hi_n + 5'd5);
        end
      end
      erlm_pkg::ActWidth: begin
        if (percent_i == 8'd0) begin
          mask_o[erlm_pkg::LedCentre] = 1'b1;
        end else if (percent_i == 8'd100) begin
          mask_o = erlm_pkg::low_bits(5'(erlm_pkg::FillMax));
        end else begin
          mask_o = erlm_pkg::span(5'(erlm_pkg::LedCentre - wid_n),
                                  5'(erlm_pkg::LedCentre + wid_n));
        end
      end
      erlm_pkg::ActCount: begin
        mask_o = erlm_pkg::low_bits(5'(cnt_n));
      end
      erlm_pkg::ActBit: begin
        if (percent_i inside {[8'd1:8'd15]}) begin
          mask_o[pct_m1[3:0]] = 1'b1;
        end
      end
      erlm_pkg::ActDbfs: begin
        if (level_tenth_db_i > erlm_pkg::DbFloor) begin
          if (only_position_i) begin
            mask_o[db_idx] = 1'b1;
          end else begin
            mask_o = erlm_pkg::low_bits(5'(db_idx) + 5'd1);
          end
        end
      end
      default: mask_o = '0;
    endcase
  end

endmodule
